// ----- rtl/core/bss_pkg.sv -----
// Package for the bounded stack with search: opcodes, sequencer states
// and reset constants. No dependencies; every other file imports it.
`default_nettype none

package bss_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned CAP_W         = 5;
	localparam int unsigned VALUE_W       = 32;
	localparam int unsigned INDEX_W       = 5;
	localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
	localparam logic [INDEX_W-1:0] NO_MATCH  = 5'h1F;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_FIND  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RDTOP,
		ST_LDTOP,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/bss_req_if.sv -----
// Request channel of the bounded stack: valid/ready plus opcode and value.
// Depends on bss_pkg for the field widths.
`default_nettype none

interface bss_req_if import bss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [VALUE_W-1:0] operand_value;

	modport source (output valid, opcode, operand_value, input ready);
	modport sink   (input valid, opcode, operand_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bss_rsp_if.sv -----
// Response channel of the bounded stack: valid/ready plus the result fields.
// Depends on bss_pkg for the field widths.
`default_nettype none

interface bss_rsp_if import bss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [INDEX_W-1:0] found_index;
	logic [VALUE_W-1:0] top_value;
	logic [VALUE_W-1:0] bottom_value;
	logic [CAP_W-1:0]   depth_used;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, accepted, found_index, top_value, bottom_value,
		depth_used, is_empty, is_full, input ready);
	modport sink   (input valid, accepted, found_index, top_value, bottom_value,
		depth_used, is_empty, is_full, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bounded_stack_with_search.sv -----
// Bounded LIFO stack of unsigned words with a linear search over live entries.
// Depends on bss_pkg, bss_req_if and bss_rsp_if.
//
//   channel   dir  handshake        payload
//   req       in   valid/ready      opcode, operand_value
//   rsp       out  valid/ready      accepted, found_index, top_value, bottom_value,
//                                   depth_used, is_empty, is_full
//   cfg       in   cfg_wr_en        cfg_wr_data (capacity)
//
// One request at a time: push, clear and find on an empty stack go from accept through EXEC
// to the response; a pop that leaves entries also passes RDTOP and LDTOP (top reread from the slot memory).
// Find scans the live entries from slot 0 upward: the single memory read port
// and one comparator scan one slot per cycle, stopping at the first match.
// Reset empties the stack and sets capacity to 16; slot contents are not cleared.
// A stalled response holds, and no request is taken until it is delivered.
`default_nettype none

module bounded_stack_with_search import bss_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data,
	bss_req_if.sink               req,
	bss_rsp_if.source             rsp
);

	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	state_t state_q, state_d;

	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic               lookup_s1;
	logic [CNT_W-1:0]   idx_s1;

	op_t                op_q;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] top_q;
	logic [VALUE_W-1:0] bottom_q;
	logic [INDEX_W-1:0] found_q;
	logic               accepted_q;

	logic [VALUE_W-1:0] slot_mem [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               scan_issue;
	logic               hit;

	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   eff_cap;
	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   idx_ext;
	logic               push_ok;
	logic               req_fire;

	// Effective capacity: zero acts as one, anything above the built depth as the depth
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign count_ext = CMP_W'(count_q);
	assign idx_ext   = CMP_W'(idx_s1);
	assign push_ok   = count_ext < eff_cap;
	assign req_fire  = req.valid && req.ready;
	assign hit       = lookup_s1 && (rd_data_q == val_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (op_q) inside
					OP_PUSH, OP_CLEAR: state_d = ST_RESP;
					OP_POP:  state_d = (count_q > CNT_W'(1)) ? ST_RDTOP : ST_RESP;
					OP_FIND: state_d = (count_q == '0) ? ST_RESP : ST_SCAN;
				endcase
			end
			ST_SCAN: begin
				if (hit || (!scan_issue && !lookup_s1)) state_d = ST_RESP;
			end
			ST_RDTOP: state_d = ST_LDTOP;
			ST_LDTOP: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory read control
	always_comb begin
		req.ready  = 1'b0;
		rsp.valid  = 1'b0;
		scan_issue = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = scan_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: begin
				scan_issue = (scan_q < count_q) && !hit;
				rd_en      = scan_issue;
			end
			ST_RDTOP: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(count_q - CNT_W'(1));
			end
			ST_RESP: rsp.valid = 1'b1;
			ST_EXEC, ST_LDTOP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= CAP_RESET;
			count_q   <= '0;
			scan_q    <= '0;
			lookup_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			lookup_s1 <= scan_issue;
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (scan_issue) scan_q <= scan_q + CNT_W'(1);
			if (state_q == ST_EXEC) begin
				scan_q <= '0;
				unique case (op_q)
					OP_PUSH:  if (push_ok) count_q <= count_q + CNT_W'(1);
					OP_POP:   if (count_q != '0) count_q <= count_q - CNT_W'(1);
					OP_CLEAR: count_q <= '0;
					OP_FIND:  ;
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (req_fire) begin
			op_q  <= op_t'(req.opcode);
			val_q <= req.operand_value;
		end
		if (state_q == ST_EXEC) begin
			found_q <= NO_MATCH;
			unique case (op_q) inside
				OP_PUSH: begin
					accepted_q <= push_ok;
					if (push_ok) begin
						top_q <= val_q;
						if (count_q == '0) bottom_q <= val_q;
					end
				end
				OP_POP:   accepted_q <= (count_q != '0);
				OP_FIND, OP_CLEAR: accepted_q <= 1'b1;
			endcase
		end
		// hold the first match; the scan stops on it
		if (state_q == ST_SCAN && hit) found_q <= idx_ext[INDEX_W-1:0];
		if (state_q == ST_LDTOP) top_q <= rd_data_q;
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && op_q == OP_PUSH && push_ok) begin
			slot_mem[count_q[ADDR_W-1:0]] <= val_q;
		end
		if (rd_en) rd_data_q <= slot_mem[rd_addr];
	end

	assign rsp.accepted     = accepted_q;
	assign rsp.found_index  = found_q;
	assign rsp.top_value    = (count_q == '0) ? '1 : top_q;
	assign rsp.bottom_value = (count_q == '0) ? '0 : bottom_q;
	assign rsp.depth_used   = count_ext[CAP_W-1:0];
	assign rsp.is_empty     = (count_q == '0);
	assign rsp.is_full      = (count_ext >= eff_cap);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stack count exceeds depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && op_q == OP_PUSH && push_ok)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not advance count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while response pending");

	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		scan_issue |-> scan_q < count_q)
		else $error("scan reads past live entries");

	a_found_only_find: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && op_q != OP_FIND) |-> rsp.found_index == NO_MATCH)
		else $error("match index reported for non-find request");
`endif

endmodule

`default_nettype wire
